>>> rtl/pwl_waveform_merge_combine_assert.svh
// Assertion macros for the waveform merge block.
`ifndef PWL_WAVEFORM_MERGE_COMBINE_ASSERT_SVH
`define PWL_WAVEFORM_MERGE_COMBINE_ASSERT_SVH
`ifndef SYNTHESIS
`define PWLMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pwlmc assertion failed");
`define PWLMC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("pwlmc assertion failed");
`else
`define PWLMC_ASSERT(lbl, prop)
`define PWLMC_ASSERT_NR(lbl, prop)
`endif
`endif

>>> rtl/pwlmc_pkg.sv
package pwlmc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;
  localparam int unsigned MD_W      = 34;
  localparam int unsigned PROD_W    = 2 * MD_W;
  localparam int unsigned CNT_W     = $clog2(PROD_W);
  localparam int unsigned OB_DEPTH  = 4;
  localparam int unsigned OB_IW     = $clog2(OB_DEPTH);
  localparam int unsigned OB_NW     = OB_IW + 1;
  localparam logic [2:0]  PRIME_N   = 3'd4;

  localparam logic signed [MD_W-1:0] ONE_MD = MD_W'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0]     FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_AVG = 4'd2;
  localparam logic [3:0] OP_MAX = 4'd3;
  localparam logic [3:0] OP_MIN = 4'd4;
  localparam logic [3:0] OP_MUL = 4'd5;
  localparam logic [3:0] OP_WRP = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_LAM = 4'd8;

  localparam logic [1:0] STAT_RUN = 2'd0;
  localparam logic [1:0] STAT_END = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  // breakpoint select: {from B, current point}
  localparam logic [1:0] SEL_A_PREV = 2'b00;
  localparam logic [1:0] SEL_A_CUR  = 2'b01;
  localparam logic [1:0] SEL_B_PREV = 2'b10;
  localparam logic [1:0] SEL_B_CUR  = 2'b11;

  // overlap codes: <B prev place><B cur place> against A (L below, P at prev,
  // M between, C at cur, H above)
  localparam logic [4:0] CC_LL = 5'd0;
  localparam logic [4:0] CC_LP = 5'd1;
  localparam logic [4:0] CC_LM = 5'd2;
  localparam logic [4:0] CC_LC = 5'd3;
  localparam logic [4:0] CC_LH = 5'd4;
  localparam logic [4:0] CC_PM = 5'd7;
  localparam logic [4:0] CC_PC = 5'd8;
  localparam logic [4:0] CC_PH = 5'd9;
  localparam logic [4:0] CC_MM = 5'd12;
  localparam logic [4:0] CC_MC = 5'd13;
  localparam logic [4:0] CC_MH = 5'd14;
  localparam logic [4:0] CC_CH = 5'd19;
  localparam logic [4:0] CC_HH = 5'd24;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic                   start;
    logic signed [MD_W-1:0] a;
    logic signed [MD_W-1:0] b;
    logic signed [MD_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] q;
  } md_rsp_t;

  typedef struct packed {
    logic  pv;
    word_t t;
    word_t v;
    word_t s;
  } res_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       flush;
    logic       ns;
    logic [1:0] st;
  } ob_ctl_t;

  function automatic logic signed [63:0] sx64(input word_t w);
    return {{(64-DW){w[DW-1]}}, w};
  endfunction

  function automatic logic signed [MD_W-1:0] sx34(input word_t w);
    return {{(MD_W-DW){w[DW-1]}}, w};
  endfunction

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > sx64({1'b0, {(DW-1){1'b1}}})) return {1'b0, {(DW-1){1'b1}}};
    if (v < sx64({1'b1, {(DW-1){1'b0}}})) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

  function automatic logic [4:0] docode(input word_t tb2, input word_t tb,
                                        input word_t ta2, input word_t ta);
    logic [4:0] c1;
    logic [4:0] c2;
    if (tb <= ta2) c1 = (tb == ta2) ? CC_LP : CC_LL;
    else if (tb < ta) c1 = CC_LM;
    else if (tb == ta) c1 = CC_LC;
    else c1 = CC_LH;
    if (tb2 <= ta2) c2 = (tb2 == ta2) ? 5'd5 : 5'd0;
    else if (tb2 < ta) c2 = 5'd10;
    else if (tb2 == ta) c2 = 5'd15;
    else c2 = 5'd20;
    return c1 + c2;
  endfunction

  function automatic logic good_code(input logic [4:0] c);
    return c inside {CC_LL, CC_LP, CC_LM, CC_LC, CC_LH, CC_PM, CC_PC, CC_PH,
                     CC_MM, CC_MC, CC_MH, CC_CH, CC_HH};
  endfunction

  function automatic logic wants_b(input logic [4:0] c);
    return c inside {CC_LL, CC_LP, CC_LM, CC_PM, CC_MM, CC_MC};
  endfunction

endpackage

>>> rtl/pwlmc_muldiv.sv
`include "pwl_waveform_merge_combine_assert.svh"

module pwlmc_muldiv import pwlmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [PROD_W-1:0] LIM_Q = PROD_W'(1) << 62;

  logic [1:0]        ph_q, ph_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MD_W-1:0]   ua_q, ua_d, ub_q, ub_d, uc_q, uc_d;
  logic [PROD_W-1:0] p_q, p_d;
  logic [MD_W-1:0]   r_q, r_d;
  logic              neg_q, neg_d;
  logic [MD_W:0]     rs;
  logic              ge;
  logic [PROD_W-1:0] qcap;
  logic signed [63:0] q64;

  function automatic logic [MD_W-1:0] mag(input logic signed [MD_W-1:0] v);
    return v[MD_W-1] ? MD_W'(-v) : MD_W'(v);
  endfunction

  assign rs = {r_q, p_q[PROD_W-1]};
  assign ge = rs >= {1'b0, uc_q};

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    ua_d  = ua_q;
    ub_d  = ub_q;
    uc_d  = uc_q;
    p_d   = p_q;
    r_d   = r_q;
    neg_d = neg_q;
    case (ph_q)
      PH_IDLE: begin
        if (req_i.start) begin
          ua_d  = mag(req_i.a);
          ub_d  = mag(req_i.b);
          uc_d  = mag(req_i.c);
          neg_d = req_i.a[MD_W-1] ^ req_i.b[MD_W-1] ^ req_i.c[MD_W-1];
          p_d   = '0;
          cnt_d = CNT_W'(MD_W - 1);
          ph_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        p_d  = (p_q << 1) + (ub_q[MD_W-1] ? {{(PROD_W-MD_W){1'b0}}, ua_q} : '0);
        ub_d = ub_q << 1;
        if (cnt_q == '0) begin
          // a divisor of one needs no divide pass
          if (uc_q == MD_W'(1)) begin
            ph_d = PH_DONE;
          end else begin
            cnt_d = CNT_W'(PROD_W - 1);
            r_d   = '0;
            ph_d  = PH_DIV;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      PH_DIV: begin
        r_d = ge ? MD_W'(rs - {1'b0, uc_q}) : rs[MD_W-1:0];
        p_d = {p_q[PROD_W-2:0], ge};
        if (cnt_q == '0) ph_d = PH_DONE;
        else cnt_d = cnt_q - 1'b1;
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    uc_q  <= uc_d;
    p_q   <= p_d;
    r_q   <= r_d;
    neg_q <= neg_d;
  end

  assign qcap = (p_q > LIM_Q) ? LIM_Q : p_q;
  assign q64  = qcap[63:0];

  assign rsp_o.done = (ph_q == PH_DONE);
  assign rsp_o.q    = (uc_q == '0) ? '0 : (neg_q ? -q64 : q64);

  `PWLMC_ASSERT(a_md_start_idle, req_i.start |-> ph_q == PH_IDLE)

endmodule

>>> rtl/pwlmc_outbuf.sv
`include "pwl_waveform_merge_combine_assert.svh"

module pwlmc_outbuf import pwlmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ob_ctl_t     ctl_i,
  input  res_t        res_i,
  output logic        busy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // out_time, out_value, out_second
  output logic [3:0]  m_axis_tuser,  // point_valid, next_stream, status[1:0]
  output logic        m_axis_tlast
);

  res_t             ent_q [OB_DEPTH];
  logic [OB_NW-1:0] n_q;
  logic [OB_IW-1:0] rd_q;
  logic             drain_q;
  logic             ns_q;
  logic [1:0]       st_q;
  res_t             cur;
  logic             at_end;

  assign cur    = ent_q[rd_q];
  assign at_end = ({1'b0, rd_q} == n_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      rd_q    <= '0;
      drain_q <= 1'b0;
      ns_q    <= 1'b0;
      st_q    <= STAT_RUN;
    end else begin
      if (ctl_i.clear) begin
        n_q <= '0;
      end else if (ctl_i.push) begin
        n_q <= n_q + 1'b1;
      end else if (ctl_i.flush) begin
        if (n_q == '0) n_q <= OB_NW'(1);
        drain_q <= 1'b1;
        rd_q    <= '0;
        ns_q    <= ctl_i.ns;
        st_q    <= ctl_i.st;
      end else if (drain_q && m_axis_tready) begin
        if (at_end) drain_q <= 1'b0;
        else rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      ent_q[n_q[OB_IW-1:0]] <= res_i;
    end else if (ctl_i.flush && n_q == '0) begin
      ent_q[0] <= '0;
    end
  end

  assign busy_o        = drain_q;
  assign m_axis_tvalid = drain_q;
  assign m_axis_tdata  = {cur.s, cur.v, cur.t};
  assign m_axis_tuser  = {st_q, ns_q, cur.pv};
  assign m_axis_tlast  = at_end;

  `PWLMC_ASSERT(a_ob_count, drain_q |-> (n_q != '0 && n_q <= OB_NW'(OB_DEPTH)))
  `PWLMC_ASSERT(a_ob_no_push_drain, drain_q |-> !ctl_i.push)
  `PWLMC_ASSERT_NR(a_ob_reset_idle, !rst_ni |-> !m_axis_tvalid)

endmodule

>>> rtl/pwl_waveform_merge_combine.sv
// Merges two piecewise-linear Q16.16 waveforms. The block names the stream it
// wants on tuser bit 1 of every result beat; input beats from the other stream
// are dropped, and tlast on an input beat ends the run. Every input beat gives
// one to four result beats, the final one with tlast set. Each linear
// interpolation, crossing point, multiply or divide goes through one shared
// shift-add multiply and restoring divide unit, which skips the divide pass
// when the divisor is one, as for a multiply. A beat needs up to six of them
// (two breakpoints, each with an interpolation and, for max or min, a
// crossing time and value). The input is not ready until all result beats
// of the previous one have been taken.
`include "pwl_waveform_merge_combine_assert.svh"

module pwl_waveform_merge_combine import pwlmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,   // combine_op
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_time, sample_value
  input  logic [0:0]  s_axis_tuser,  // stream_id
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // out_time, out_value, out_second
  output logic [3:0]  m_axis_tuser,  // point_valid, next_stream, status[1:0]
  output logic        m_axis_tlast
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROC   = 4'd1;
  localparam logic [3:0] S_EMIT   = 4'd2;
  localparam logic [3:0] S_IWAIT  = 4'd3;
  localparam logic [3:0] S_SEED   = 4'd4;
  localparam logic [3:0] S_COMB   = 4'd5;
  localparam logic [3:0] S_CWAIT  = 4'd6;
  localparam logic [3:0] S_XWAIT1 = 4'd7;
  localparam logic [3:0] S_XCHK   = 4'd8;
  localparam logic [3:0] S_XWAIT2 = 4'd9;
  localparam logic [3:0] S_XFIN   = 4'd10;
  localparam logic [3:0] S_NEXT   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_q, state_d;
  word_t      atp_q, atp_d, avp_q, avp_d, atc_q, atc_d, avc_q, avc_d;
  word_t      btp_q, btp_d, bvp_q, bvp_d, btc_q, btc_d, bvc_q, bvc_d;
  word_t      lot_q, lot_d, ot_q, ot_d, oa_q, oa_d, ob_q, ob_d;
  word_t      tt_q, tt_d, xx_q, xx_d, yy_q, yy_d, tc_q, tc_d;
  logic       seen_q, seen_d, fin_q, fin_d, init_q, init_d, e_q, e_d;
  logic [2:0] prime_q, prime_d;
  logic [3:0] op_q;
  logic [1:0] sel1_q, sel1_d, sel2_q, sel2_d;

  md_req_t md_req;
  md_rsp_t md_rsp;
  ob_ctl_t ob_ctl;
  res_t    ob_res;
  logic    ob_busy;

  logic [4:0] code_w;
  logic       want_w;
  logic [1:0] status_w;
  logic [1:0] sel_w;
  word_t      tt_w, own_w, ot2_w, ov2_w, ot1_w, ov1_w, iv_w, mm_w;
  logic signed [32:0] s33, avg33;
  logic signed [63:0] md_q, prod_w;
  logic       cross_w, do_commit;
  logic       md_wait_w;
  logic       in_sid, in_eos;
  word_t      in_t, in_v;

  assign in_sid = s_axis_tuser[0];
  assign in_eos = s_axis_tlast;
  assign in_t   = s_axis_tdata[31:0];
  assign in_v   = s_axis_tdata[63:32];

  assign code_w   = docode(btp_q, btc_q, atp_q, atc_q);
  assign want_w   = (fin_q || prime_q < 3'd2) ? 1'b0 :
                    (prime_q < PRIME_N) ? 1'b1 : wants_b(code_w);
  assign status_w = !fin_q ? STAT_RUN :
                    (prime_q >= PRIME_N && !good_code(code_w)) ? STAT_BAD : STAT_END;

  assign sel_w = e_q ? sel2_q : sel1_q;
  always_comb begin
    case (sel_w)
      SEL_A_PREV: begin tt_w = atp_q; own_w = avp_q; end
      SEL_A_CUR:  begin tt_w = atc_q; own_w = avc_q; end
      SEL_B_PREV: begin tt_w = btp_q; own_w = bvp_q; end
      default:    begin tt_w = btc_q; own_w = bvc_q; end
    endcase
    if (sel_w[1]) begin
      ot2_w = atp_q; ov2_w = avp_q; ot1_w = atc_q; ov1_w = avc_q;
    end else begin
      ot2_w = btp_q; ov2_w = bvp_q; ot1_w = btc_q; ov1_w = bvc_q;
    end
  end

  assign md_q    = md_rsp.q;
  // product scaled back to Q16.16, truncated toward zero
  assign prod_w  = (md_q + (md_q[63] ? FRAC_MASK : 64'sd0)) >>> FRAC_BITS;
  assign iv_w    = sat32(sx64(ov1_w) + md_q);
  assign mm_w    = (op_q == OP_MAX) ? ((xx_q > yy_q) ? xx_q : yy_q)
                                    : ((xx_q < yy_q) ? xx_q : yy_q);
  assign cross_w = (oa_q > ob_q && xx_q < yy_q) || (oa_q < ob_q && xx_q > yy_q);
  assign s33     = {xx_q[DW-1], xx_q} + {yy_q[DW-1], yy_q};
  assign avg33   = (s33 + {32'd0, s33[32] & s33[0]}) >>> 1;

  always_comb begin
    state_d = state_q;
    atp_d = atp_q; avp_d = avp_q; atc_d = atc_q; avc_d = avc_q;
    btp_d = btp_q; bvp_d = bvp_q; btc_d = btc_q; bvc_d = bvc_q;
    lot_d = lot_q; ot_d = ot_q; oa_d = oa_q; ob_d = ob_q;
    tt_d = tt_q; xx_d = xx_q; yy_d = yy_q; tc_d = tc_q;
    seen_d = seen_q; fin_d = fin_q; init_d = init_q; e_d = e_q;
    prime_d = prime_q; sel1_d = sel1_q; sel2_d = sel2_q;
    md_req    = '0;
    ob_ctl    = '0;
    ob_ctl.ns = want_w;
    ob_ctl.st = status_w;
    ob_res    = '0;
    do_commit = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ob_ctl.clear = 1'b1;
          state_d = S_OUT;
          if (!fin_q) begin
            if (in_eos) begin
              fin_d = 1'b1;
            end else if (in_sid == want_w) begin
              if (in_sid) begin
                btp_d = btc_q; bvp_d = bvc_q; btc_d = in_t; bvc_d = in_v;
              end else begin
                atp_d = atc_q; avp_d = avc_q; atc_d = in_t; avc_d = in_v;
              end
              init_d = 1'b0;
              if (prime_q < PRIME_N) begin
                prime_d = prime_q + 1'b1;
                if (prime_q == PRIME_N - 1'b1) begin
                  init_d  = 1'b1;
                  state_d = S_PROC;
                end
              end else begin
                state_d = S_PROC;
              end
            end
          end
        end
      end
      S_PROC: begin
        if (init_q) lot_d = (btp_q < atp_q) ? btp_q : atp_q;
        e_d     = 1'b0;
        state_d = S_EMIT;
        case (code_w)
          CC_LL, CC_HH: state_d = S_OUT;
          CC_LP, CC_LM, CC_PM: begin sel1_d = SEL_A_PREV; sel2_d = SEL_B_CUR; end
          CC_MM, CC_MC:        begin sel1_d = SEL_B_PREV; sel2_d = SEL_B_CUR; end
          CC_LC, CC_LH, CC_PC: begin sel1_d = SEL_A_PREV; sel2_d = SEL_A_CUR; end
          CC_PH, CC_MH, CC_CH: begin sel1_d = SEL_B_PREV; sel2_d = SEL_A_CUR; end
          default: begin
            fin_d   = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_EMIT: begin
        tt_d = tt_w;
        if (sel_w[1]) yy_d = own_w;
        else xx_d = own_w;
        if (ot1_w == ot2_w) begin
          if (sel_w[1]) xx_d = ov1_w;
          else yy_d = ov1_w;
          state_d = S_SEED;
        end else begin
          md_req.start = 1'b1;
          md_req.a = sx34(ov2_w) - sx34(ov1_w);
          md_req.b = sx34(tt_w) - sx34(ot1_w);
          md_req.c = sx34(ot2_w) - sx34(ot1_w);
          state_d = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (md_rsp.done) begin
          if (sel_w[1]) xx_d = iv_w;
          else yy_d = iv_w;
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        if (!seen_q) begin
          ot_d = tt_q; oa_d = xx_q; ob_d = yy_q; seen_d = 1'b1;
        end
        state_d = S_COMB;
      end
      S_COMB: begin
        state_d  = S_NEXT;
        ob_res.t = tt_q;
        ob_res.pv = 1'b1;
        if (op_q <= OP_LAM && tt_q > lot_q) begin
          case (op_q)
            OP_ADD: begin
              ob_res.v = sat32(sx64(xx_q) + sx64(yy_q));
              ob_ctl.push = 1'b1; do_commit = 1'b1;
            end
            OP_SUB: begin
              ob_res.v = sat32(sx64(xx_q) - sx64(yy_q));
              ob_ctl.push = 1'b1; do_commit = 1'b1;
            end
            OP_AVG: begin
              ob_res.v = avg33[DW-1:0];
              ob_ctl.push = 1'b1; do_commit = 1'b1;
            end
            OP_MAX, OP_MIN: begin
              if (cross_w) begin
                md_req.start = 1'b1;
                md_req.a = sx34(tt_q) - sx34(ot_q);
                md_req.b = sx34(ob_q) - sx34(oa_q);
                md_req.c = (sx34(xx_q) - sx34(oa_q)) - (sx34(yy_q) - sx34(ob_q));
                state_d = S_XWAIT1;
              end else begin
                ob_res.v = mm_w;
                ob_ctl.push = 1'b1; do_commit = 1'b1;
              end
            end
            OP_MUL: begin
              md_req.start = 1'b1;
              md_req.a = sx34(xx_q);
              md_req.b = sx34(yy_q);
              md_req.c = MD_W'(1);
              state_d = S_CWAIT;
            end
            OP_WRP: begin
              ob_res.t = sat32(sx64(tt_q) + sx64(yy_q));
              ob_res.v = xx_q;
              ob_ctl.push = 1'b1; do_commit = 1'b1;
            end
            OP_DIV: begin
              if (yy_q == '0) begin
                ob_res.v = (xx_q == '0) ? '0 :
                           xx_q[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                ob_ctl.push = 1'b1; do_commit = 1'b1;
              end else begin
                md_req.start = 1'b1;
                md_req.a = sx34(xx_q);
                md_req.b = ONE_MD;
                md_req.c = sx34(yy_q);
                state_d = S_CWAIT;
              end
            end
            default: begin
              ob_res.v = xx_q;
              ob_res.s = yy_q;
              ob_ctl.push = 1'b1; do_commit = 1'b1;
            end
          endcase
        end
      end
      S_CWAIT: begin
        if (md_rsp.done) begin
          ob_res.pv = 1'b1;
          ob_res.t  = tt_q;
          ob_res.v  = (op_q == OP_MUL) ? sat32(prod_w) : sat32(md_q);
          ob_ctl.push = 1'b1; do_commit = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_XWAIT1: begin
        if (md_rsp.done) begin
          tc_d    = sat32(sx64(ot_q) + md_q);
          state_d = S_XCHK;
        end
      end
      S_XCHK: begin
        if (tc_q > lot_q && tt_q != ot_q) begin
          md_req.start = 1'b1;
          md_req.a = sx34(yy_q) - sx34(ob_q);
          md_req.b = sx34(tc_q) - sx34(ot_q);
          md_req.c = sx34(tt_q) - sx34(ot_q);
          state_d = S_XWAIT2;
        end else begin
          ob_res.pv = 1'b1;
          ob_res.t  = tt_q;
          ob_res.v  = mm_w;
          ob_ctl.push = 1'b1; do_commit = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_XWAIT2: begin
        if (md_rsp.done) begin
          ob_res.pv = 1'b1;
          ob_res.t  = tc_q;
          ob_res.v  = sat32(sx64(ob_q) + md_q);
          ob_ctl.push = 1'b1;
          state_d = S_XFIN;
        end
      end
      S_XFIN: begin
        ob_res.pv = 1'b1;
        ob_res.t  = tt_q;
        ob_res.v  = mm_w;
        ob_ctl.push = 1'b1; do_commit = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (!e_q) begin
          e_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        ob_ctl.flush = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (do_commit) begin
      lot_d = tt_q; ot_d = tt_q; oa_d = xx_q; ob_d = yy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      atp_q <= '0; avp_q <= '0; atc_q <= '0; avc_q <= '0;
      btp_q <= '0; bvp_q <= '0; btc_q <= '0; bvc_q <= '0;
      lot_q <= '0; ot_q <= '0; oa_q <= '0; ob_q <= '0;
      seen_q  <= 1'b0;
      fin_q   <= 1'b0;
      init_q  <= 1'b0;
      e_q     <= 1'b0;
      prime_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) op_q <= cfg_wdata_i;
      atp_q <= atp_d; avp_q <= avp_d; atc_q <= atc_d; avc_q <= avc_d;
      btp_q <= btp_d; bvp_q <= bvp_d; btc_q <= btc_d; bvc_q <= bvc_d;
      lot_q <= lot_d; ot_q <= ot_d; oa_q <= oa_d; ob_q <= ob_d;
      seen_q  <= seen_d;
      fin_q   <= fin_d;
      init_q  <= init_d;
      e_q     <= e_d;
      prime_q <= prime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tt_q   <= tt_d;
    xx_q   <= xx_d;
    yy_q   <= yy_d;
    tc_q   <= tc_d;
    sel1_q <= sel1_d;
    sel2_q <= sel2_d;
  end

  assign s_axis_tready = (state_q == S_IDLE) && !ob_busy;
  assign md_wait_w     = (state_q == S_IWAIT) || (state_q == S_CWAIT) ||
                         (state_q == S_XWAIT1) || (state_q == S_XWAIT2);

  pwlmc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  pwlmc_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ob_ctl),
    .res_i         (ob_res),
    .busy_o        (ob_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `PWLMC_ASSERT(a_in_out_apart, !(s_axis_tready && m_axis_tvalid))
  `PWLMC_ASSERT(a_prime_range, prime_q <= PRIME_N)
  `PWLMC_ASSERT(a_md_done_waiting, md_rsp.done |-> md_wait_w)

endmodule
